// File: src/bffa_pkg.sv
// Shared constants and codes for the bitmap first-free allocator.
package bffa_pkg;

  localparam int MAP_BITS_DEF  = 8192;
  localparam int WORD_BITS_DEF = 32;

  localparam int IDX_W    = 14;
  localparam int STATUS_W = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FREE  = 2'd3;

endpackage

// File: src/bffa_req_if.sv
// Request channel: command and entry index with valid/ready handshake.
interface bffa_req_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [bffa_pkg::IDX_W-1:0]  entry_index;

  modport source (output valid, command, entry_index, input ready);
  modport sink   (input valid, command, entry_index, output ready);
endinterface

// File: src/bffa_rsp_if.sv
// Response channel: allocated index, status and free count with valid/ready handshake.
interface bffa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [bffa_pkg::IDX_W-1:0]     result_index;
  logic [bffa_pkg::STATUS_W-1:0]  status;
  logic [bffa_pkg::IDX_W-1:0]     free_count;

  modport source (output valid, result_index, status, free_count, input ready);
  modport sink   (input valid, result_index, status, free_count, output ready);
endinterface

// File: src/bffa_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bffa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/bffa_find_zero.sv
// Priority encoder: position of the lowest clear bit of a bitmap word.
module bffa_find_zero #(
  parameter int WORD_BITS = 32
) (
  input  logic [WORD_BITS-1:0]         word,
  output logic                         found,
  output logic [$clog2(WORD_BITS)-1:0] pos
);

  localparam int BW = $clog2(WORD_BITS);

  always_comb begin
    pos = '0;
    // scan downward so the lowest clear bit wins
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        pos = BW'(i);
      end
    end
  end

  assign found = ~&word;

endmodule

// File: src/bitmap_first_free_allocator_top.sv
// Bitmap first-free allocator top level: control sequencer, bitmap RAM and response register.
//
// The allocation bitmap lives in one RAM of ceil(MAP_BITS/WORD_BITS) words with a registered
// read; a set bit marks an allocated entry. After reset the block runs a clearing pass over
// every word with req.ready low. An allocate reads the map one word per cycle from word 0
// until a word holds a clear bit, reading 1 up to ceil(MAP_BITS/WORD_BITS) words; the single
// RAM read port limits the scan to one word at a time. A free splits the index, reads the
// word, then checks the bit and writes it back; a free with an out-of-range index skips these
// steps. One request is in flight at a time; the next request is taken while the previous
// response still waits in the output register.
module bitmap_first_free_allocator_top #(
  parameter int MAP_BITS  = bffa_pkg::MAP_BITS_DEF,
  parameter int WORD_BITS = bffa_pkg::WORD_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  bffa_req_if.sink      req,
  bffa_rsp_if.source    rsp
);

  localparam int IW        = bffa_pkg::IDX_W;
  localparam int SW        = bffa_pkg::STATUS_W;
  localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int CW        = $clog2(MAP_BITS + 1);
  localparam int EW        = AW + BW + 1;
  localparam int LAST_BITS = MAP_BITS - (MAP_WORDS - 1) * WORD_BITS;
  localparam int DIV_S     = IW + $clog2(WORD_BITS);
  localparam int DIV_R     = ((2 ** DIV_S) + WORD_BITS - 1) / WORD_BITS;
  localparam int PW        = IW + DIV_S + 1;

  localparam logic [AW-1:0]        LAST_ADDR  = AW'(MAP_WORDS - 1);
  localparam logic [WORD_BITS-1:0] LAST_MASK  = {WORD_BITS{1'b1}} << LAST_BITS;
  localparam logic [31:0]          MAP_BITS_V = 32'(MAP_BITS);
  localparam logic [CW-1:0]        CNT_MAX    = CW'(MAP_BITS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FDIV  = 3'd3;
  localparam logic [2:0] S_FRD   = 3'd4;
  localparam logic [2:0] S_FCHK  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]           state;
  logic [AW-1:0]        word_addr;
  logic [IW-1:0]        idx_m1;
  logic [IW-1:0]        quot;
  logic [BW-1:0]        bit_pos;
  logic [CW-1:0]        free_cnt;
  logic [IW-1:0]        res_index;
  logic [SW-1:0]        res_status;
  logic                 out_valid;
  logic [IW-1:0]        out_index;
  logic [SW-1:0]        out_status;
  logic [IW-1:0]        out_count;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [WORD_BITS-1:0] scan_word;
  logic                 zero_found;
  logic [BW-1:0]        zero_pos;
  logic [EW-1:0]        alloc_num;
  logic [PW-1:0]        div_prod;
  logic [IW-1:0]        rem_full;
  logic                 in_accept;
  logic                 idx_bad;
  logic                 last_word;

  assign in_accept = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign idx_bad   = (req.entry_index == '0) || (32'(req.entry_index) > MAP_BITS_V);
  assign last_word = (word_addr == LAST_ADDR);

  // bits past the end of the map count as taken
  assign scan_word = ram_rdata | (last_word ? LAST_MASK : '0);
  assign alloc_num = (EW'(word_addr) * EW'(WORD_BITS)) + EW'(zero_pos) + EW'(1);

  // split the zero-based index into word and bit by reciprocal multiply
  assign div_prod = PW'(idx_m1) * PW'(DIV_R);
  assign rem_full = idx_m1 - (quot * IW'(WORD_BITS));

  bffa_find_zero #(.WORD_BITS(WORD_BITS)) u_find (
    .word  (scan_word),
    .found (zero_found),
    .pos   (zero_pos)
  );

  bffa_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = word_addr;
    ram_wdata = '0;
    ram_raddr = '0;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_SCAN: begin
        ram_raddr = word_addr + AW'(1);
        ram_we    = zero_found;
        ram_wdata = ram_rdata | (WORD_BITS'(1) << zero_pos);
      end
      S_FRD: begin
        ram_raddr = AW'(quot);
      end
      S_FCHK: begin
        ram_waddr = AW'(quot);
        ram_we    = ram_rdata[bit_pos];
        ram_wdata = ram_rdata & ~(WORD_BITS'(1) << bit_pos);
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      word_addr <= '0;
      free_cnt  <= CNT_MAX;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          word_addr <= word_addr + AW'(1);
          if (last_word) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            res_index <= '0;
            if (req.command == bffa_pkg::CMD_ALLOC) begin
              word_addr <= '0;
              state     <= S_SCAN;
            end else if (idx_bad) begin
              res_status <= bffa_pkg::ST_RANGE;
              state      <= S_DONE;
            end else begin
              idx_m1 <= req.entry_index - IW'(1);
              state  <= S_FDIV;
            end
          end
        end
        S_SCAN: begin
          if (zero_found) begin
            res_index  <= IW'(alloc_num);
            res_status <= bffa_pkg::ST_OK;
            free_cnt   <= free_cnt - CW'(1);
            state      <= S_DONE;
          end else if (last_word) begin
            res_status <= bffa_pkg::ST_FULL;
            state      <= S_DONE;
          end else begin
            word_addr <= word_addr + AW'(1);
          end
        end
        S_FDIV: begin
          quot  <= IW'(div_prod >> DIV_S);
          state <= S_FRD;
        end
        S_FRD: begin
          bit_pos <= BW'(rem_full);
          state   <= S_FCHK;
        end
        S_FCHK: begin
          if (ram_rdata[bit_pos]) begin
            res_status <= bffa_pkg::ST_OK;
            free_cnt   <= free_cnt + CW'(1);
          end else begin
            res_status <= bffa_pkg::ST_FREE;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_index  <= res_index;
            out_status <= res_status;
            out_count  <= IW'(free_cnt);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.result_index = out_index;
  assign rsp.status       = out_status;
  assign rsp.free_count   = out_count;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_cnt <= CNT_MAX)
    else $error("free count above map size");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !req.ready)
    else $error("request accepted while another is in progress");

  a_index_needs_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.result_index != '0) |-> (rsp.status == bffa_pkg::ST_OK))
    else $error("nonzero result index with failing status");

  a_count_tracks_map: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (free_cnt != $past(free_cnt))) |-> $past(ram_we))
    else $error("free count changed without a map write");

endmodule
